/* rtl/jclm_pkg.sv */
// ---------------------------------------------------------------------------
// jclm_pkg: joint command limit monitor definitions
// Field widths, fault and register codes, reset values and per-joint maxima.
// ---------------------------------------------------------------------------
package jclm_pkg;

  // arm size and field widths
  localparam int NUM_JOINTS = 7;
  localparam int JOINT_W    = 3;
  localparam int TQ_W       = 16;
  localparam int VEL_W      = 16;
  localparam int POS_W      = 17;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CODE_W     = 3;

  // two slots per joint address: {slot, joint}
  localparam int MEM_AW    = JOINT_W + 1;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  // fault codes
  localparam logic [CODE_W-1:0] FAULT_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] FAULT_TORQUE = 3'd1;
  localparam logic [CODE_W-1:0] FAULT_STEP   = 3'd2;
  localparam logic [CODE_W-1:0] FAULT_VEL    = 3'd3;
  localparam logic [CODE_W-1:0] FAULT_POS    = 3'd4;

  // item opcodes and bound select
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_LIMIT    = 1'b1;
  localparam logic BOUND_LOWER = 1'b0;
  localparam logic BOUND_UPPER = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MARGIN = 2'd1;

  // register and bound reset values
  localparam logic [CFG_W-1:0] STEP_LIMIT_RST = 16'd100;
  localparam logic [CFG_W-1:0] MARGIN_RST     = 16'd100;
  localparam logic [POS_W-1:0] LOWER_RST      = 17'h10000;
  localparam logic [POS_W-1:0] UPPER_RST      = 17'h0FFFF;

  typedef logic [TQ_W-1:0]  torque_t;
  typedef logic [POS_W-1:0] bound_t;

  // torque maximum per joint, 0.01 Nm
  function automatic logic [TQ_W:0] torque_max(input logic [JOINT_W-1:0] j);
    logic [TQ_W:0] m;
    if (j < 3'd4) begin
      m = 17'd8700;
    end else begin
      m = 17'd1200;
    end
    return m;
  endfunction

  // velocity maximum per joint, 0.001 rad/s
  function automatic logic [VEL_W:0] velocity_max(input logic [JOINT_W-1:0] j);
    logic [VEL_W:0] m;
    unique case (j)
      3'd0, 3'd1, 3'd2, 3'd3: m = 17'd2620;
      3'd5:                   m = 17'd4180;
      default:                m = 17'd5260;
    endcase
    return m;
  endfunction

endpackage

/* rtl/joint_command_limit_monitor_top.sv */
// ---------------------------------------------------------------------------
// joint_command_limit_monitor_top: per-tick safety check of joint commands
// Checks torque range, torque step, velocity and position limits of each
// joint sample and reports the first fault of every control tick.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake         | beat contents
//  --------+-----------+-------------------+----------------------------------
//  in_     | input     | in_valid/in_stall | op, joint, seed, torque, velocity,
//          |           |                   | position, bound_sel, limit_value
//  out_    | output    | out_valid/out_stall | fault_code, fault_joint
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One beat per cycle while in_stall is low. A beat is read from the torque
//  and bound memories in the cycle it is taken, then checked and written back
//  from the check stage, and the tick result is then held in the output register.
//  Reset clears all control state; bounds read as full range until written.
//  in_stall rises only while a tick-ending beat waits in the check stage
//  behind an untaken result; cfg_ready is always high.
// ---------------------------------------------------------------------------
module joint_command_limit_monitor_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample / limit-write channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [jclm_pkg::JOINT_W-1:0]         in_joint,
  input  logic                                 in_seed,
  input  logic signed [jclm_pkg::TQ_W-1:0]     in_torque,
  input  logic signed [jclm_pkg::VEL_W-1:0]    in_velocity,
  input  logic signed [jclm_pkg::POS_W-1:0]    in_position,
  input  logic                                 in_bound_sel,
  input  logic signed [jclm_pkg::POS_W-1:0]    in_limit_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [jclm_pkg::CODE_W-1:0]          out_fault_code,
  output logic [jclm_pkg::JOINT_W-1:0]         out_fault_joint,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jclm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jclm_pkg::CFG_W-1:0]           cfg_data
);

  localparam int NJ = jclm_pkg::NUM_JOINTS;

  // configuration registers
  logic [jclm_pkg::CFG_W-1:0] step_limit_r;
  logic [jclm_pkg::CFG_W-1:0] margin_r;

  // memories
  jclm_pkg::torque_t tq_mem [jclm_pkg::MEM_DEPTH];
  jclm_pkg::bound_t  bnd_mem [jclm_pkg::MEM_DEPTH];
  jclm_pkg::torque_t tq_q0_r, tq_q1_r;
  jclm_pkg::bound_t  bnd_lo_q_r, bnd_hi_q_r;

  // write ports
  logic                            tq_we;
  logic [jclm_pkg::MEM_AW-1:0]     tq_waddr;
  logic                            bnd_we;
  logic [jclm_pkg::MEM_AW-1:0]     bnd_waddr;

  // forwarding of the write that shared the read edge
  logic                            tq_fwd_vld_r;
  logic [jclm_pkg::MEM_AW-1:0]     tq_fwd_addr_r;
  jclm_pkg::torque_t               tq_fwd_data_r;
  logic                            bnd_fwd_vld_r;
  logic [jclm_pkg::MEM_AW-1:0]     bnd_fwd_addr_r;
  jclm_pkg::bound_t                bnd_fwd_data_r;

  // per-joint torque slot bookkeeping and latch bits
  logic [NJ-1:0] wsel_r, wsel_nxt;     // slot holding latest torque
  logic [NJ-1:0] cmt_r, cmt_nxt;       // previous equals latest slot
  logic [NJ-1:0] zero_r, zero_nxt;     // previous still at reset value
  logic [NJ-1:0] trip_r, trip_nxt;
  logic [jclm_pkg::MEM_DEPTH-1:0] bnd_vld_r, bnd_vld_nxt;

  // tick state
  logic [jclm_pkg::CODE_W-1:0]  tick_code_r, tick_code_nxt;
  logic [jclm_pkg::JOINT_W-1:0] tick_joint_r, tick_joint_nxt;
  logic                         tick_seed_r, tick_seed_nxt;

  // check stage
  logic                              s1_valid_r, s1_valid_nxt;
  logic                              s1_op_r;
  logic [jclm_pkg::JOINT_W-1:0]      s1_joint_r;
  logic                              s1_seed_r;
  logic signed [jclm_pkg::TQ_W-1:0]  s1_torque_r;
  logic signed [jclm_pkg::VEL_W-1:0] s1_vel_r;
  logic signed [jclm_pkg::POS_W-1:0] s1_pos_r;
  logic                              s1_sel_r;
  logic signed [jclm_pkg::POS_W-1:0] s1_limit_r;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [jclm_pkg::CODE_W-1:0]   out_code_r, out_code_nxt;
  logic [jclm_pkg::JOINT_W-1:0]  out_joint_r, out_joint_nxt;

  logic in_acc, s1_fire, s1_hold, s1_jok, s1_sample, s1_ends;
  logic seed_eff, commit, pos_out, pos_reached;
  logic prev_slot, wr_slot;
  jclm_pkg::torque_t tq_rd0, tq_rd1, prev_tq;
  jclm_pkg::bound_t  lo_bnd, hi_bnd;
  logic [jclm_pkg::TQ_W:0]   abs_tq, abs_step;
  logic [jclm_pkg::VEL_W:0]  abs_vel;
  logic signed [jclm_pkg::TQ_W:0]  step_diff;
  logic signed [jclm_pkg::POS_W:0] lo_lim, hi_lim, pos_x;
  logic [jclm_pkg::CODE_W-1:0] code_c, code_new;
  logic [jclm_pkg::MEM_AW-1:0] lo_addr, hi_addr;

  // handshakes
  assign cfg_ready = 1'b1;
  assign s1_ends   = s1_valid_r && s1_sample &&
                     (s1_joint_r == jclm_pkg::JOINT_W'(NJ - 1));
  assign s1_hold   = s1_ends && out_valid_r && out_stall;
  assign s1_fire   = s1_valid_r && !s1_hold;
  assign in_stall  = s1_hold;
  assign in_acc    = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_fault_code  = out_code_r;
  assign out_fault_joint = out_joint_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_limit_r <= jclm_pkg::STEP_LIMIT_RST;
      margin_r     <= jclm_pkg::MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == jclm_pkg::CFG_IDX_STEP) begin
        step_limit_r <= cfg_data;
      end else if (cfg_index == jclm_pkg::CFG_IDX_MARGIN) begin
        margin_r <= cfg_data;
      end
    end
  end

  // memories: read both slots on accept, write back from the check stage
  always_ff @(posedge clk) begin
    if (tq_we) begin
      tq_mem[tq_waddr] <= s1_torque_r;
    end
    if (bnd_we) begin
      bnd_mem[bnd_waddr] <= s1_limit_r;
    end
    if (in_acc) begin
      tq_q0_r    <= tq_mem[{1'b0, in_joint}];
      tq_q1_r    <= tq_mem[{1'b1, in_joint}];
      bnd_lo_q_r <= bnd_mem[{jclm_pkg::BOUND_LOWER, in_joint}];
      bnd_hi_q_r <= bnd_mem[{jclm_pkg::BOUND_UPPER, in_joint}];
    end
  end

  // forwarding registers, captured with the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tq_fwd_vld_r  <= 1'b0;
      bnd_fwd_vld_r <= 1'b0;
    end else if (in_acc) begin
      tq_fwd_vld_r  <= tq_we;
      bnd_fwd_vld_r <= bnd_we;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tq_fwd_addr_r  <= tq_waddr;
      tq_fwd_data_r  <= s1_torque_r;
      bnd_fwd_addr_r <= bnd_waddr;
      bnd_fwd_data_r <= s1_limit_r;
    end
  end

  // check stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_op;
      s1_joint_r  <= in_joint;
      s1_seed_r   <= in_seed;
      s1_torque_r <= in_torque;
      s1_vel_r    <= in_velocity;
      s1_pos_r    <= in_position;
      s1_sel_r    <= in_bound_sel;
      s1_limit_r  <= in_limit_value;
    end
  end

  // read data with forwarding
  always_comb begin
    lo_addr = {jclm_pkg::BOUND_LOWER, s1_joint_r};
    hi_addr = {jclm_pkg::BOUND_UPPER, s1_joint_r};

    tq_rd0 = (tq_fwd_vld_r && tq_fwd_addr_r == {1'b0, s1_joint_r}) ?
             tq_fwd_data_r : tq_q0_r;
    tq_rd1 = (tq_fwd_vld_r && tq_fwd_addr_r == {1'b1, s1_joint_r}) ?
             tq_fwd_data_r : tq_q1_r;

    if (bnd_fwd_vld_r && bnd_fwd_addr_r == lo_addr) begin
      lo_bnd = bnd_fwd_data_r;
    end else if (bnd_vld_r[lo_addr]) begin
      lo_bnd = bnd_lo_q_r;
    end else begin
      lo_bnd = jclm_pkg::LOWER_RST;
    end

    if (bnd_fwd_vld_r && bnd_fwd_addr_r == hi_addr) begin
      hi_bnd = bnd_fwd_data_r;
    end else if (bnd_vld_r[hi_addr]) begin
      hi_bnd = bnd_hi_q_r;
    end else begin
      hi_bnd = jclm_pkg::UPPER_RST;
    end
  end

  // joint checks
  always_comb begin
    s1_jok    = (s1_joint_r < jclm_pkg::JOINT_W'(NJ));
    s1_sample = (s1_op_r == jclm_pkg::OP_SAMPLE) && s1_jok;
    seed_eff  = tick_seed_r || s1_seed_r;

    prev_slot = cmt_r[s1_joint_r] ? wsel_r[s1_joint_r] : !wsel_r[s1_joint_r];
    if (zero_r[s1_joint_r]) begin
      prev_tq = '0;
    end else begin
      prev_tq = prev_slot ? tq_rd1 : tq_rd0;
    end

    abs_tq    = s1_torque_r[jclm_pkg::TQ_W-1] ?
                (17'd0 - {s1_torque_r[jclm_pkg::TQ_W-1], s1_torque_r}) :
                {1'b0, s1_torque_r};
    step_diff = $signed({s1_torque_r[jclm_pkg::TQ_W-1], s1_torque_r}) -
                $signed({prev_tq[jclm_pkg::TQ_W-1], prev_tq});
    abs_step  = step_diff[jclm_pkg::TQ_W] ? (17'd0 - step_diff) : step_diff;
    abs_vel   = s1_vel_r[jclm_pkg::VEL_W-1] ?
                (17'd0 - {s1_vel_r[jclm_pkg::VEL_W-1], s1_vel_r}) :
                {1'b0, s1_vel_r};

    // limits pulled in by the margin
    lo_lim  = $signed({lo_bnd[jclm_pkg::POS_W-1], lo_bnd}) +
              $signed({2'b00, margin_r});
    hi_lim  = $signed({hi_bnd[jclm_pkg::POS_W-1], hi_bnd}) -
              $signed({2'b00, margin_r});
    pos_x   = {s1_pos_r[jclm_pkg::POS_W-1], s1_pos_r};
    pos_out = (pos_x < lo_lim) || (pos_x > hi_lim);

    pos_reached = 1'b0;
    priority if (abs_tq > jclm_pkg::torque_max(s1_joint_r)) begin
      code_c = jclm_pkg::FAULT_TORQUE;
    end else if (!seed_eff && abs_step > {1'b0, step_limit_r}) begin
      code_c = jclm_pkg::FAULT_STEP;
    end else if (abs_vel > jclm_pkg::velocity_max(s1_joint_r)) begin
      code_c = jclm_pkg::FAULT_VEL;
    end else begin
      pos_reached = 1'b1;
      code_c = (pos_out && !trip_r[s1_joint_r]) ? jclm_pkg::FAULT_POS :
               jclm_pkg::FAULT_NONE;
    end

    code_new = (tick_code_r != jclm_pkg::FAULT_NONE) ? tick_code_r : code_c;
    commit   = seed_eff || (code_new < jclm_pkg::FAULT_VEL);
    wr_slot  = cmt_r[s1_joint_r] ? !wsel_r[s1_joint_r] : wsel_r[s1_joint_r];
  end

  // state updates of the check stage
  always_comb begin
    wsel_nxt       = wsel_r;
    cmt_nxt        = cmt_r;
    zero_nxt       = zero_r;
    trip_nxt       = trip_r;
    bnd_vld_nxt    = bnd_vld_r;
    tick_code_nxt  = tick_code_r;
    tick_joint_nxt = tick_joint_r;
    tick_seed_nxt  = tick_seed_r;
    out_code_nxt   = out_code_r;
    out_joint_nxt  = out_joint_r;
    tq_we          = 1'b0;
    tq_waddr       = {wr_slot, s1_joint_r};
    bnd_we         = 1'b0;
    bnd_waddr      = {s1_sel_r, s1_joint_r};

    // output register drains on a taken beat
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    if (s1_fire && s1_jok && s1_op_r == jclm_pkg::OP_LIMIT) begin
      bnd_we                 = 1'b1;
      bnd_vld_nxt[bnd_waddr] = 1'b1;
    end

    if (s1_fire && s1_sample) begin
      // latest torque goes to the slot not holding the previous one
      tq_we                  = 1'b1;
      wsel_nxt[s1_joint_r]   = wr_slot;
      cmt_nxt[s1_joint_r]    = 1'b0;

      if (tick_code_r == jclm_pkg::FAULT_NONE && pos_reached) begin
        trip_nxt[s1_joint_r] = pos_out;
      end

      if (s1_ends) begin
        if (commit) begin
          cmt_nxt  = '1;
          zero_nxt = '0;
        end
        out_valid_nxt  = 1'b1;
        out_code_nxt   = code_new;
        out_joint_nxt  = (code_new != jclm_pkg::FAULT_NONE) ?
                         ((tick_code_r != jclm_pkg::FAULT_NONE) ?
                          tick_joint_r : s1_joint_r) : '0;
        tick_code_nxt  = jclm_pkg::FAULT_NONE;
        tick_joint_nxt = '0;
        tick_seed_nxt  = 1'b0;
      end else begin
        tick_seed_nxt = seed_eff;
        if (tick_code_r == jclm_pkg::FAULT_NONE &&
            code_c != jclm_pkg::FAULT_NONE) begin
          tick_code_nxt  = code_c;
          tick_joint_nxt = s1_joint_r;
        end
      end
    end

    // check stage occupancy
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      wsel_r       <= '0;
      cmt_r        <= '0;
      zero_r       <= '1;
      trip_r       <= '0;
      bnd_vld_r    <= '0;
      tick_code_r  <= jclm_pkg::FAULT_NONE;
      tick_joint_r <= '0;
      tick_seed_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      wsel_r       <= wsel_nxt;
      cmt_r        <= cmt_nxt;
      zero_r       <= zero_nxt;
      trip_r       <= trip_nxt;
      bnd_vld_r    <= bnd_vld_nxt;
      tick_code_r  <= tick_code_nxt;
      tick_joint_r <= tick_joint_nxt;
      tick_seed_r  <= tick_seed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_code_r  <= out_code_nxt;
    out_joint_r <= out_joint_nxt;
  end

endmodule
